FILE: rtl/core/slsc_pkg.sv
// slsc_pkg: types, character codes and status codes for the shell line syntax checker
// no dependencies
package slsc_pkg;

  localparam int CharW   = 8;
  localparam int StatusW = 3;
  localparam int TdataW  = 8;

  localparam logic [CharW-1:0] CH_NUL  = 8'h00;
  localparam logic [CharW-1:0] CH_SQ   = 8'h27;
  localparam logic [CharW-1:0] CH_DQ   = 8'h22;
  localparam logic [CharW-1:0] CH_LT   = 8'h3C;
  localparam logic [CharW-1:0] CH_GT   = 8'h3E;
  localparam logic [CharW-1:0] CH_PIPE = 8'h7C;
  localparam logic [CharW-1:0] CH_AMP  = 8'h26;
  localparam logic [CharW-1:0] CH_TAB  = 8'h09;
  localparam logic [CharW-1:0] CH_CR   = 8'h0D;
  localparam logic [CharW-1:0] CH_SP   = 8'h20;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_QUOTE    = 3'd1;
  localparam logic [StatusW-1:0] ST_LOGICAL  = 3'd2;
  localparam logic [StatusW-1:0] ST_OPERATOR = 3'd3;
  localparam logic [StatusW-1:0] ST_REDIRECT = 3'd4;

  typedef enum logic [1:0] {
    QUOTE_NONE,
    QUOTE_SINGLE,
    QUOTE_DOUBLE
  } quote_t;

  typedef enum logic [1:0] {
    REDIR_IDLE,
    REDIR_FIRST,
    REDIR_SKIP
  } redir_t;

  typedef struct packed {
    quote_t open_quote;
    logic   single_parity;
    logic   double_parity;
    logic   at_line_start;
    logic   prev_amp_unquoted;
    logic   prev_pipe_unquoted;
    logic   logical_error;
    logic   operator_pending;
    logic   operator_error;
    redir_t redirect_phase;
    logic   redirect_is_greater;
    logic   redirect_error;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    open_quote:          QUOTE_NONE,
    single_parity:       1'b0,
    double_parity:       1'b0,
    at_line_start:       1'b1,
    prev_amp_unquoted:   1'b0,
    prev_pipe_unquoted:  1'b0,
    logical_error:       1'b0,
    operator_pending:    1'b0,
    operator_error:      1'b0,
    redirect_phase:      REDIR_IDLE,
    redirect_is_greater: 1'b0,
    redirect_error:      1'b0
  };

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op(input logic [CharW-1:0] c);
    return (c == CH_PIPE) || (c == CH_AMP);
  endfunction

endpackage

FILE: rtl/core/slsc_scan.sv
// slsc_scan: next-state and status logic for one character of the line
// depends on slsc_pkg
module slsc_scan
  import slsc_pkg::*;
(
  input  scan_state_t            cur,
  input  logic [CharW-1:0]       char_code,
  output scan_state_t            nxt,
  output logic                   term,
  output logic [StatusW-1:0]     status
);

  logic   even;
  logic   sp;
  logic   op;
  logic   angle;
  logic   sp_nxt;
  logic   dp_nxt;
  redir_t phase;

  always_comb begin
    term   = (char_code == CH_NUL);
    sp     = is_space(char_code);
    op     = is_op(char_code);
    angle  = (char_code == CH_LT) || (char_code == CH_GT);
    sp_nxt = cur.single_parity ^ (char_code == CH_SQ);
    dp_nxt = cur.double_parity ^ (char_code == CH_DQ);
    even   = !sp_nxt && !dp_nxt;

    if (cur.open_quote != QUOTE_NONE) begin
      status = ST_QUOTE;
    end else if (cur.logical_error) begin
      status = ST_LOGICAL;
    end else if (cur.operator_error || cur.operator_pending) begin
      status = ST_OPERATOR;
    end else if (cur.redirect_error || cur.redirect_phase != REDIR_IDLE) begin
      status = ST_REDIRECT;
    end else begin
      status = ST_OK;
    end

    nxt = cur;
    nxt.single_parity = sp_nxt;
    nxt.double_parity = dp_nxt;

    // open quote tracking
    if (char_code == CH_SQ) begin
      if (cur.open_quote == QUOTE_NONE) nxt.open_quote = QUOTE_SINGLE;
      else if (cur.open_quote == QUOTE_SINGLE) nxt.open_quote = QUOTE_NONE;
    end else if (char_code == CH_DQ) begin
      if (cur.open_quote == QUOTE_NONE) nxt.open_quote = QUOTE_DOUBLE;
      else if (cur.open_quote == QUOTE_DOUBLE) nxt.open_quote = QUOTE_NONE;
    end

    // doubled logical operators
    if ((cur.prev_amp_unquoted && char_code == CH_AMP) ||
        (cur.prev_pipe_unquoted && char_code == CH_PIPE)) begin
      nxt.logical_error = 1'b1;
    end
    nxt.prev_amp_unquoted  = even && (char_code == CH_AMP);
    nxt.prev_pipe_unquoted = even && (char_code == CH_PIPE);

    // misplaced pipe or ampersand
    if (cur.at_line_start && op) nxt.operator_error = 1'b1;
    nxt.at_line_start = 1'b0;
    if (op && even) begin
      if (cur.operator_pending) nxt.operator_error = 1'b1;
      nxt.operator_pending = 1'b1;
    end else if (!sp) begin
      nxt.operator_pending = 1'b0;
    end

    // misplaced redirection
    phase = cur.redirect_phase;
    if (phase == REDIR_FIRST) begin
      phase = REDIR_SKIP;
    end
    unique case (cur.redirect_phase)
      REDIR_FIRST,
      REDIR_SKIP: begin
        if (cur.redirect_phase == REDIR_FIRST &&
            char_code == (cur.redirect_is_greater ? CH_GT : CH_LT)) begin
          nxt.redirect_phase = REDIR_SKIP;
        end else if (sp) begin
          nxt.redirect_phase = phase;
        end else begin
          if (op || angle) nxt.redirect_error = 1'b1;
          nxt.redirect_phase = REDIR_IDLE;
        end
      end
      default: begin
        if (angle && even) begin
          nxt.redirect_phase      = REDIR_FIRST;
          nxt.redirect_is_greater = (char_code == CH_GT);
        end
      end
    endcase

    if (term) nxt = SCAN_RESET;
  end

endmodule

FILE: rtl/core/shell_line_syntax_checker.sv
// shell_line_syntax_checker: top level, input register, scan state and result register
// depends on slsc_pkg and slsc_scan
// a terminator byte is held in the input register, then its status is registered in the result register
// throughput: one byte per cycle, but a terminator byte waits while an earlier status is still held at the output
// reset: synchronous active-low rst_n clears the scan state and both stages
// a status waiting at the output does not stop non-terminator bytes
module shell_line_syntax_checker
  import slsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TdataW-1:0] in_tdata,   // [7:0] char_code
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [TdataW-1:0] out_tdata   // [2:0] status, [7:3] zero
);

  logic                in_valid_r;
  logic [CharW-1:0]    char_r;
  scan_state_t         state_r;
  scan_state_t         state_nxt;
  logic                out_valid_r;
  logic [StatusW-1:0]  status_r;
  logic                term;
  logic [StatusW-1:0]  status;
  logic                advance;

  slsc_scan u_scan (
    .cur       (state_r),
    .char_code (char_r),
    .nxt       (state_nxt),
    .term      (term),
    .status    (status)
  );

  assign advance   = in_valid_r && (!term || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      state_r     <= SCAN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) state_r <= state_nxt;
      if (advance && term) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) char_r <= in_tdata[CharW-1:0];
    if (advance && term) status_r <= status;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TdataW-StatusW){1'b0}}, status_r};

  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && term |=> out_tvalid)
    else $error("terminator did not produce a status");

  a_line_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.at_line_start |-> (!state_r.single_parity && !state_r.double_parity &&
                               state_r.open_quote == QUOTE_NONE &&
                               state_r.redirect_phase == REDIR_IDLE))
    else $error("scan state not clear at line start");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && term |=> state_r.at_line_start)
    else $error("scan state not reset after terminator");

endmodule

FILE: tb/tb_shell_line_syntax_checker.sv
// tb_shell_line_syntax_checker: self-checking testbench for the shell line syntax checker
// feeds directed and random command lines byte by byte, predicts each line status or takes it from the directed table
// depends on slsc_pkg and shell_line_syntax_checker
module tb_shell_line_syntax_checker;
  import slsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 400;
  localparam int RandomItems = 1400;
  localparam int DrainCycles = 8;
  localparam int DirN        = 24;

  typedef struct {
    quote_t quote;
    bit     sq_odd;
    bit     dq_odd;
    bit     fresh;
    bit     amp_prev;
    bit     pipe_prev;
    bit     dbl_err;
    bit     op_wait;
    bit     op_err;
    redir_t redir;
    bit     redir_gt;
    bit     redir_err;
  } line_scan_t;

  typedef struct {
    logic [CharW-1:0]   ch;
    bit                 typed;
    logic [StatusW-1:0] st;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [TdataW-1:0] in_tdata;   // [7:0] char_code
  logic              out_tvalid;
  logic              out_tready;
  logic [TdataW-1:0] out_tdata;  // [2:0] status, [7:3] zero

  line_scan_t         scan;
  logic [StatusW-1:0] status_q[$];
  int                 err_count = 0;
  int                 sent = 0;
  int                 idle_cycles = 0;
  bit                 in_burst = 1'b0;
  bit                 out_burst = 1'b0;

  dir_row_t dir_rows [DirN] = '{
    '{CH_NUL, 1'b1, ST_OK},
    '{8'hFF, 1'b0, ST_OK}, '{CH_AMP, 1'b0, ST_OK}, '{CH_AMP, 1'b0, ST_OK},
    '{CH_NUL, 1'b1, ST_LOGICAL},
    '{CH_SQ, 1'b0, ST_OK}, '{CH_NUL, 1'b1, ST_QUOTE},
    '{CH_PIPE, 1'b0, ST_OK}, '{CH_NUL, 1'b1, ST_OPERATOR},
    '{CH_GT, 1'b0, ST_OK}, '{CH_NUL, 1'b1, ST_REDIRECT},
    '{"x", 1'b0, ST_OK}, '{CH_GT, 1'b0, ST_OK}, '{CH_GT, 1'b0, ST_OK},
    '{CH_CR, 1'b0, ST_OK}, '{"y", 1'b0, ST_OK}, '{CH_NUL, 1'b0, ST_OK},
    '{CH_DQ, 1'b0, ST_OK}, '{CH_SQ, 1'b0, ST_OK}, '{CH_DQ, 1'b0, ST_OK},
    '{CH_NUL, 1'b0, ST_OK},
    '{CH_LT, 1'b0, ST_OK}, '{CH_AMP, 1'b0, ST_OK}, '{CH_NUL, 1'b0, ST_OK}
  };

  shell_line_syntax_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic line_scan_t fresh_scan();
    line_scan_t s;
    s.quote     = QUOTE_NONE;
    s.sq_odd    = 1'b0;
    s.dq_odd    = 1'b0;
    s.fresh     = 1'b1;
    s.amp_prev  = 1'b0;
    s.pipe_prev = 1'b0;
    s.dbl_err   = 1'b0;
    s.op_wait   = 1'b0;
    s.op_err    = 1'b0;
    s.redir     = REDIR_IDLE;
    s.redir_gt  = 1'b0;
    s.redir_err = 1'b0;
    return s;
  endfunction

  // advances the line scan by one byte, returns 1 when a status is due
  function automatic bit scan_char(input logic [CharW-1:0] c, output logic [StatusW-1:0] st);
    bit even;
    bit blank;
    bit opc;
    bit angle;
    st = ST_OK;
    if (c == CH_NUL) begin
      if (scan.quote != QUOTE_NONE) st = ST_QUOTE;
      else if (scan.dbl_err) st = ST_LOGICAL;
      else if (scan.op_err || scan.op_wait) st = ST_OPERATOR;
      else if (scan.redir_err || scan.redir != REDIR_IDLE) st = ST_REDIRECT;
      scan = fresh_scan();
      return 1'b1;
    end
    if (c == CH_SQ) begin
      if (scan.quote == QUOTE_NONE) scan.quote = QUOTE_SINGLE;
      else if (scan.quote == QUOTE_SINGLE) scan.quote = QUOTE_NONE;
      scan.sq_odd = !scan.sq_odd;
    end
    if (c == CH_DQ) begin
      if (scan.quote == QUOTE_NONE) scan.quote = QUOTE_DOUBLE;
      else if (scan.quote == QUOTE_DOUBLE) scan.quote = QUOTE_NONE;
      scan.dq_odd = !scan.dq_odd;
    end
    even  = !scan.sq_odd && !scan.dq_odd;
    blank = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    opc   = (c == CH_PIPE) || (c == CH_AMP);
    angle = (c == CH_LT) || (c == CH_GT);

    if ((scan.amp_prev && c == CH_AMP) || (scan.pipe_prev && c == CH_PIPE)) scan.dbl_err = 1'b1;
    scan.amp_prev  = even && (c == CH_AMP);
    scan.pipe_prev = even && (c == CH_PIPE);

    if (scan.fresh && opc) scan.op_err = 1'b1;
    scan.fresh = 1'b0;
    if (opc && even) begin
      if (scan.op_wait) scan.op_err = 1'b1;
      scan.op_wait = 1'b1;
    end else if (!blank) begin
      scan.op_wait = 1'b0;
    end

    case (scan.redir)
      REDIR_FIRST: begin
        if (c == (scan.redir_gt ? CH_GT : CH_LT)) begin
          scan.redir = REDIR_SKIP;
        end else if (blank) begin
          scan.redir = REDIR_SKIP;
        end else begin
          if (opc || angle) scan.redir_err = 1'b1;
          scan.redir = REDIR_IDLE;
        end
      end
      REDIR_SKIP: begin
        if (!blank) begin
          if (opc || angle) scan.redir_err = 1'b1;
          scan.redir = REDIR_IDLE;
        end
      end
      default: begin
        if (angle && even) begin
          scan.redir    = REDIR_FIRST;
          scan.redir_gt = (c == CH_GT);
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic push_char(input logic [CharW-1:0] b, input bit typed,
                           input logic [StatusW-1:0] typed_st);
    int gap;
    logic [StatusW-1:0] st;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent++;
    if (scan_char(b, st)) status_q.push_back(typed ? typed_st : st);
  endtask

  function automatic logic [CharW-1:0] pick_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SP : CH_TAB + r[CharW-1:0];
  endfunction

  task automatic push_token();
    int kind;
    int n;
    logic [CharW-1:0] q;
    logic [CharW-1:0] b;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        n = $urandom_range(1, 4);
        repeat (n) push_char(CharW'($urandom_range(8'h21, 8'h7E)), 1'b0, ST_OK);
      end
      2: begin
        n = $urandom_range(1, 2);
        repeat (n) push_char(pick_blank(), 1'b0, ST_OK);
      end
      3, 4: begin
        q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        push_char(q, 1'b0, ST_OK);
        n = $urandom_range(0, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: b = CH_SQ;
            1: b = CH_DQ;
            2: b = $urandom_range(0, 1) ? CH_PIPE : CH_GT;
            default: b = CharW'($urandom_range(8'h21, 8'h7E));
          endcase
          push_char(b, 1'b0, ST_OK);
        end
        push_char(q, 1'b0, ST_OK);
      end
      5: begin
        b = $urandom_range(0, 1) ? CH_PIPE : CH_AMP;
        push_char(b, 1'b0, ST_OK);
        if ($urandom_range(0, 2) == 0) push_char(b, 1'b0, ST_OK);
      end
      6: begin
        b = $urandom_range(0, 1) ? CH_LT : CH_GT;
        push_char(b, 1'b0, ST_OK);
        if ($urandom_range(0, 2) == 0) push_char(b, 1'b0, ST_OK);
      end
      7: push_char($urandom_range(0, 1) ? CH_SQ : CH_DQ, 1'b0, ST_OK);
      default: push_char(CharW'($urandom_range(1, 255)), 1'b0, ST_OK);
    endcase
  endtask

  always @(posedge clk) begin
    logic [StatusW-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        report_mismatch("unexpected status item", int'(out_tdata[StatusW-1:0]), -1);
      end else begin
        want = status_q.pop_front();
        if (out_tdata[StatusW-1:0] !== want)
          report_mismatch("status", int'(out_tdata[StatusW-1:0]), int'(want));
        if (out_tdata[TdataW-1:StatusW] !== '0)
          report_mismatch("tdata pad bits", int'(out_tdata[TdataW-1:StatusW]), 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("timeout with %0d status items outstanding", status_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int g;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      g = out_burst ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    int ntok;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    scan      = fresh_scan();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) push_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].st);

    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 7) == 0) in_burst = !in_burst;
      if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
      ntok = $urandom_range(0, 6);
      repeat (ntok) push_token();
      push_char(CH_NUL, 1'b0, ST_OK);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
